[design/assert_macros.svh]
// Assertion macros used by the checker file tcacc_checker.sv.
// Assumes the including scope has clk and arst_n (async reset, active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, clocked on clk, off during reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/tcacc_pkg.sv]
// Shared types and constants for the 64.64 uptime accumulator.
// No dependencies; imported by the controller, datapath and top level.
package tcacc_pkg;

	localparam int COUNTER_BITS = 64;
	localparam logic [63:0] COUNT_WMASK = 64'(~64'd0 >> (64 - COUNTER_BITS));
	localparam logic [31:0] NS_PER_S = 32'd1000000000;
	localparam logic [31:0] US_PER_S = 32'd1000000;
	localparam int ACC_W = 128;
	localparam int NS_W = 30;
	localparam int US_W = 20;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_UPTIME = 2'd1,
		MODE_WALL   = 2'd2,
		MODE_REBASE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE     = 3'd0,
		CFG_SCALE      = 3'd1,
		CFG_CMASK      = 3'd2,
		CFG_BOOT_SEC   = 3'd3,
		CFG_BOOT_FRAC  = 3'd4
	} cfg_reg_t;

	// Partial-product selects for the shared 32x32 multiplier
	typedef enum logic [2:0] {
		OP_LL,
		OP_LH,
		OP_HL,
		OP_HH,
		OP_NS_L,
		OP_NS_H,
		OP_US_L,
		OP_US_H
	} op_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_MDRAIN,
		S_SUM,
		S_WALL,
		S_N0,
		S_N1,
		S_NDRAIN,
		S_U0,
		S_U1,
		S_UDRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    in_load;
		logic    acc_clr;
		logic    mul_issue;
		op_sel_t mul_op;
		logic    sum;
		logic    wall;
		logic    ns_cap;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic  enable;
		mode_t mode;
		logic  out_free;
	} dp_status_t;

endpackage

[design/tcacc_ctrl.sv]
// Sequencer for the uptime accumulator: walks each item through the steps.
// Depends on tcacc_pkg; drives the datapath through dp_cmd_t only.
module tcacc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tcacc_pkg::dp_status_t  status,
	output tcacc_pkg::dp_cmd_t     cmd
);
	import tcacc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_START;
			S_START: begin
				if (!status.enable)
					state_d = S_DONE;
				else if (status.mode == MODE_REBASE)
					state_d = S_SUM;
				else
					state_d = S_M0;
			end
			S_M0:     state_d = S_M1;
			S_M1:     state_d = S_M2;
			S_M2:     state_d = S_M3;
			S_M3:     state_d = S_MDRAIN;
			S_MDRAIN: state_d = S_SUM;
			S_SUM:    state_d = (status.mode == MODE_WALL) ? S_WALL : S_N0;
			S_WALL:   state_d = S_N0;
			S_N0:     state_d = S_N1;
			S_N1:     state_d = S_NDRAIN;
			S_NDRAIN: state_d = S_U0;
			S_U0:     state_d = S_U1;
			S_U1:     state_d = S_UDRAIN;
			S_UDRAIN: state_d = S_DONE;
			S_DONE:   if (status.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.mul_op = OP_LL;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
				cmd.acc_clr = in_valid;
			end
			S_M0: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_LL;
			end
			S_M1: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_LH;
			end
			S_M2: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_HL;
			end
			S_M3: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_HH;
			end
			S_SUM:  cmd.sum  = 1'b1;
			S_WALL: cmd.wall = 1'b1;
			S_N0: begin
				cmd.acc_clr   = 1'b1;
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_NS_L;
			end
			S_N1: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_NS_H;
			end
			S_U0: begin
				// ns result is read out of the accumulator as it is cleared
				cmd.ns_cap    = 1'b1;
				cmd.acc_clr   = 1'b1;
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_US_L;
			end
			S_U1: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_op    = OP_US_H;
			end
			S_DONE: cmd.out_load = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

[design/tcacc_dp.sv]
// Datapath: config registers, time state, shared 32x32 multiply-accumulate,
// 128-bit adders and the output register. Depends on tcacc_pkg.
module tcacc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tcacc_pkg::dp_cmd_t               cmd,
	output tcacc_pkg::dp_status_t            status,
	input  logic [1:0]                       mode,
	input  logic [63:0]                      count,
	input  logic                             cfg_valid,
	input  logic [tcacc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                      cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             valid_res,
	output logic [63:0]                      seconds,
	output logic [63:0]                      fraction,
	output logic [tcacc_pkg::NS_W-1:0]       nanoseconds,
	output logic [tcacc_pkg::US_W-1:0]       microseconds
);
	import tcacc_pkg::*;

	// config
	logic        enable_q;
	logic [63:0] scale_q, cmask_q, boot_sec_q, boot_frac_q;
	// time state
	logic [63:0] off_sec_q, off_frac_q, base_q;
	// per-item working registers
	mode_t       mode_q;
	logic [63:0] count_q, delta_q;
	logic [63:0] time_sec_q, time_frac_q;
	logic [NS_W-1:0] ns_q;
	logic [ACC_W-1:0] acc_q;
	// multiplier stage
	logic [31:0] mul_a, mul_b;
	logic [1:0]  mul_sh;
	logic [63:0] prod_s1;
	logic [1:0]  sh_s1;
	logic        pv_s1;
	logic [ACC_W-1:0] sum_w;
	logic [63:0] count_m;
	// output register
	logic        out_valid_q;
	logic        res_valid_q;
	logic [63:0] res_sec_q, res_frac_q;
	logic [NS_W-1:0] res_ns_q;
	logic [US_W-1:0] res_us_q;

	assign count_m = count & COUNT_WMASK;
	assign sum_w   = {off_sec_q, off_frac_q} + acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			scale_q     <= '0;
			cmask_q     <= '0;
			boot_sec_q  <= '0;
			boot_frac_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ENABLE:    enable_q    <= cfg_data[0];
				CFG_SCALE:     scale_q     <= cfg_data;
				CFG_CMASK:     cmask_q     <= cfg_data;
				CFG_BOOT_SEC:  boot_sec_q  <= cfg_data;
				CFG_BOOT_FRAC: boot_frac_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_sec_q  <= '0;
			off_frac_q <= '0;
			base_q     <= '0;
		end else if (cmd.sum) begin
			if (mode_q == MODE_TICK) begin
				off_sec_q  <= sum_w[127:64];
				off_frac_q <= sum_w[63:0];
				base_q     <= count_q;
			end else if (mode_q == MODE_REBASE) begin
				base_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			mode_q  <= mode_t'(mode);
			count_q <= count_m;
			delta_q <= (count_m - base_q) & cmask_q & COUNT_WMASK;
		end
		if (cmd.sum) begin
			if (mode_q == MODE_REBASE) begin
				time_sec_q  <= off_sec_q;
				time_frac_q <= off_frac_q;
			end else begin
				time_sec_q  <= sum_w[127:64];
				time_frac_q <= sum_w[63:0];
			end
		end else if (cmd.wall) begin
			{time_sec_q, time_frac_q} <= {time_sec_q, time_frac_q}
				+ {boot_sec_q, boot_frac_q};
		end
		if (cmd.ns_cap)
			ns_q <= acc_q[64 +: NS_W];
	end

	// operand select for the shared multiplier; shift is in 32-bit units
	always_comb begin
		mul_a  = delta_q[31:0];
		mul_b  = scale_q[31:0];
		mul_sh = 2'd0;
		unique case (cmd.mul_op)
			OP_LL: begin
				mul_a = delta_q[31:0];  mul_b = scale_q[31:0];  mul_sh = 2'd0;
			end
			OP_LH: begin
				mul_a = delta_q[31:0];  mul_b = scale_q[63:32]; mul_sh = 2'd1;
			end
			OP_HL: begin
				mul_a = delta_q[63:32]; mul_b = scale_q[31:0];  mul_sh = 2'd1;
			end
			OP_HH: begin
				mul_a = delta_q[63:32]; mul_b = scale_q[63:32]; mul_sh = 2'd2;
			end
			OP_NS_L: begin
				mul_a = time_frac_q[31:0];  mul_b = NS_PER_S; mul_sh = 2'd0;
			end
			OP_NS_H: begin
				mul_a = time_frac_q[63:32]; mul_b = NS_PER_S; mul_sh = 2'd1;
			end
			OP_US_L: begin
				mul_a = time_frac_q[31:0];  mul_b = US_PER_S; mul_sh = 2'd0;
			end
			OP_US_H: begin
				mul_a = time_frac_q[63:32]; mul_b = US_PER_S; mul_sh = 2'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {32'd0, mul_a} * {32'd0, mul_b};
		sh_s1   <= mul_sh;
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (pv_s1)
			acc_q <= acc_q + (ACC_W'(prod_s1) << {sh_s1, 5'd0});
	end

	// output register; a new result may load while the old one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_valid_q <= enable_q;
			res_sec_q   <= enable_q ? time_sec_q : '0;
			res_frac_q  <= enable_q ? time_frac_q : '0;
			res_ns_q    <= enable_q ? ns_q : '0;
			res_us_q    <= enable_q ? acc_q[64 +: US_W] : '0;
		end
	end

	assign status.enable   = enable_q;
	assign status.mode     = mode_q;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign valid_res    = res_valid_q;
	assign seconds      = res_sec_q;
	assign fraction     = res_frac_q;
	assign nanoseconds  = res_ns_q;
	assign microseconds = res_us_q;

endmodule

[design/timecounter_accumulator.sv]
// Top level of the 64.64 uptime accumulator: controller plus datapath.
// Depends on tcacc_pkg, tcacc_ctrl and tcacc_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | mode, count
//  out     | out_valid/ out_ready | valid_res, seconds, fraction, nanoseconds, microseconds
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One item at a time. After accept the sequencer runs the four partial products of
// delta*scale (skipped for rebase), the sum, the wall-time add (wall mode only) and
// the ns and us scaling, two partial products each, then loads the output register;
// when disabled it goes straight to the load. It goes back to idle before taking the
// next item. All products share the single 32x32 multiply-accumulate unit.
// Reset clears config, stored time and control; cfg_ready is always high.
// A stalled output holds the block in its last step; the next item waits.
module timecounter_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic [63:0]                      count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             valid_res,
	output logic [63:0]                      seconds,
	output logic [63:0]                      fraction,
	output logic [tcacc_pkg::NS_W-1:0]       nanoseconds,
	output logic [tcacc_pkg::US_W-1:0]       microseconds,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tcacc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                      cfg_data
);
	import tcacc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	tcacc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcacc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.count        (count),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.valid_res    (valid_res),
		.seconds      (seconds),
		.fraction     (fraction),
		.nanoseconds  (nanoseconds),
		.microseconds (microseconds)
	);

endmodule

[design/tcacc_checker.sv]
// Port-level checks for timecounter_accumulator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tcacc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        valid_res,
	input logic [63:0] seconds,
	input logic [63:0] fraction,
	input logic [29:0] nanoseconds,
	input logic [19:0] microseconds
);

	// one item in flight: no accept right after an accept
	`ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "item accepted while busy")

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before taken")

	// disabled results carry all-zero time
	`ASSERT_PROP(a_disabled_zero, !(out_valid && !valid_res) || (seconds == 64'd0 && fraction == 64'd0 && nanoseconds == 30'd0 && microseconds == 20'd0), "disabled result not zero")

	`ASSERT_PROP(a_ns_range, !out_valid || nanoseconds < 30'd1000000000, "nanoseconds out of range")

	`ASSERT_PROP(a_us_range, !out_valid || microseconds < 20'd1000000, "microseconds out of range")

endmodule

bind timecounter_accumulator tcacc_checker u_tcacc_checker (.*);
